[src/button_gesture_digit_counter_defines.svh]
// Assertion macros for the checker of the button gesture digit counter.
`ifndef BUTTON_GESTURE_DIGIT_COUNTER_DEFINES_SVH
`define BUTTON_GESTURE_DIGIT_COUNTER_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define BGDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define BGDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bgdc_pkg.sv]
// Shared types, constants and helper functions of the button gesture digit counter.
package bgdc_pkg;

   // Field and register widths.
   localparam int CNT_W     = 16;
   localparam int DIGIT_W   = 4;
   localparam int SEG_W     = 7;
   localparam int GEST_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Depth of the queue between the front and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Item kinds carried in req_tuser.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   // Gesture codes.
   localparam logic [GEST_W-1:0] GEST_NONE   = 3'd0;
   localparam logic [GEST_W-1:0] GEST_CLICK  = 3'd1;
   localparam logic [GEST_W-1:0] GEST_DOUBLE = 3'd2;
   localparam logic [GEST_W-1:0] GEST_LSTART = 3'd3;
   localparam logic [GEST_W-1:0] GEST_LREP   = 3'd4;
   localparam logic [GEST_W-1:0] GEST_LEND   = 3'd5;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT   = 2'd3;

   // Register reset values in milliseconds.
   localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd25;
   localparam logic [CNT_W-1:0] DOUBLE_RST   = 16'd350;
   localparam logic [CNT_W-1:0] LONG_RST     = 16'd800;
   localparam logic [CNT_W-1:0] REPEAT_RST   = 16'd500;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
   localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;

   // One classified item as it travels from the front to the back end.
   typedef struct packed {
      logic is_edge;
      logic level;
   } cmd_type;

   // Common-cathode pattern of a digit, bit 0 is segment a.
   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      begin
         unique case (d)
            4'd0: s = 7'h3F;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5B;
            4'd3: s = 7'h4F;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6D;
            4'd6: s = 7'h7D;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7F;
            4'd9: s = 7'h6F;
            default: s = '0;
         endcase
         return s;
      end
   endfunction

   // Millisecond counter step that sticks at full scale.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
   endfunction

endpackage

[src/bgdc_front.sv]
// Front end: takes items from the request channel and classifies them into commands.
module bgdc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bgdc_pkg::REQ_DATA_W-1:0]     req_tdata,   // [0] pressed_level, [7:1] zero
   input  logic                                req_tuser,   // [0] opcode
   output logic                                cmd_valid,
   output bgdc_pkg::cmd_type                   cmd,
   input  logic                                cmd_ready
);

   logic              valid_ff, valid_in;
   bgdc_pkg::cmd_type cmd_ff, cmd_in;
   logic              take;

   // The stage takes a new item whenever it is empty or being drained.
   assign req_tready = !valid_ff || cmd_ready;
   assign take       = req_tvalid && req_tready;

   // Classify: a tick carries no level, an edge carries the new level.
   always_comb begin
      cmd_in.is_edge = (req_tuser == bgdc_pkg::OP_EDGE);
      cmd_in.level   = (req_tuser == bgdc_pkg::OP_EDGE) && req_tdata[0];
      valid_in       = take || (valid_ff && !cmd_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

[src/bgdc_queue.sv]
// Short first-in first-out queue of commands between the front and the back end.
module bgdc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bgdc_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output bgdc_pkg::cmd_type pop_cmd
);

   bgdc_pkg::cmd_type                entry_ff [bgdc_pkg::QUEUE_DEPTH];
   logic [bgdc_pkg::QPTR_W-1:0]      head_ff, head_in;
   logic [bgdc_pkg::QPTR_W-1:0]      tail_ff, tail_in;
   logic [bgdc_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_push, do_pop;

   assign push_ready = (count_ff != bgdc_pkg::QCNT_W'(bgdc_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == bgdc_pkg::QPTR_W'(bgdc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == bgdc_pkg::QPTR_W'(bgdc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[tail_ff] <= push_cmd;
      end
   end

endmodule

[src/bgdc_back.sv]
// Back end: gesture state, timing registers, digit update and the result register.
module bgdc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bgdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bgdc_pkg::CNT_W-1:0]          csr_wdata,
   input  logic                                cmd_valid,
   output logic                                cmd_ready,
   input  bgdc_pkg::cmd_type                   cmd,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bgdc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // Timing registers.
   logic [bgdc_pkg::CNT_W-1:0] debounce_ff, double_ff, long_ff, repeat_ff;

   // Gesture state.
   logic held_ff, held_in;
   logic long_active_ff, long_active_in;
   logic click_pending_ff, click_pending_in;
   logic skip_release_ff, skip_release_in;
   logic [bgdc_pkg::CNT_W-1:0]   since_edge_ff, since_edge_in;
   logic [bgdc_pkg::CNT_W-1:0]   since_repeat_ff, since_repeat_in;
   logic [bgdc_pkg::CNT_W-1:0]   since_release_ff, since_release_in;
   logic [bgdc_pkg::DIGIT_W-1:0] digit_ff, digit_in;

   // Result register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bgdc_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                              pop;
   logic [bgdc_pkg::GEST_W-1:0]       gesture;
   logic [bgdc_pkg::CNT_W-1:0]        se_inc, sr_inc, srel_inc;
   logic [bgdc_pkg::DIGIT_W-1:0]      digit_up, digit_down;

   // An item is carried out when the result register is free or being emptied.
   assign pop       = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign cmd_ready = !rsp_valid_ff || rsp_tready;

   assign se_inc     = bgdc_pkg::sat_inc(since_edge_ff);
   assign sr_inc     = bgdc_pkg::sat_inc(since_repeat_ff);
   assign srel_inc   = bgdc_pkg::sat_inc(since_release_ff);
   assign digit_up   = (digit_ff >= bgdc_pkg::DIGIT_MAX) ? '0 : digit_ff + 1'b1;
   assign digit_down = (digit_ff == '0 || digit_ff > bgdc_pkg::DIGIT_MAX) ?
                       bgdc_pkg::DIGIT_MAX : digit_ff - 1'b1;

   // Gesture state update for one item.
   always_comb begin
      held_in          = held_ff;
      long_active_in   = long_active_ff;
      click_pending_in = click_pending_ff;
      skip_release_in  = skip_release_ff;
      since_edge_in    = since_edge_ff;
      since_repeat_in  = since_repeat_ff;
      since_release_in = since_release_ff;
      digit_in         = digit_ff;
      gesture          = bgdc_pkg::GEST_NONE;
      if (pop) begin
         if (!cmd.is_edge) begin
            // Tick: advance the counters, then check the timeout that applies.
            since_edge_in    = se_inc;
            since_repeat_in  = sr_inc;
            since_release_in = srel_inc;
            if (held_ff) begin
               if (!long_active_ff) begin
                  if (se_inc >= long_ff) begin
                     long_active_in   = 1'b1;
                     click_pending_in = 1'b0;
                     digit_in         = digit_up;
                     since_repeat_in  = '0;
                     gesture          = bgdc_pkg::GEST_LSTART;
                  end
               end else if (sr_inc >= repeat_ff) begin
                  digit_in        = digit_up;
                  since_repeat_in = '0;
                  gesture         = bgdc_pkg::GEST_LREP;
               end
            end else if (click_pending_ff && srel_inc >= double_ff) begin
               click_pending_in = 1'b0;
               digit_in         = digit_up;
               gesture          = bgdc_pkg::GEST_CLICK;
            end
         end else if (since_edge_ff >= debounce_ff && cmd.level != held_ff) begin
            // Accepted edge.
            held_in       = cmd.level;
            since_edge_in = '0;
            if (cmd.level) begin
               if (click_pending_ff) begin
                  click_pending_in = 1'b0;
                  skip_release_in  = 1'b1;
                  digit_in         = digit_down;
                  gesture          = bgdc_pkg::GEST_DOUBLE;
               end else begin
                  long_active_in = 1'b0;
               end
            end else begin
               if (skip_release_ff) begin
                  skip_release_in = 1'b0;
               end else if (long_active_ff) begin
                  long_active_in = 1'b0;
                  gesture        = bgdc_pkg::GEST_LEND;
               end else begin
                  click_pending_in = 1'b1;
                  since_release_in = '0;
               end
            end
         end
      end
   end

   // Result packing and the valid flag of the result register.
   always_comb begin
      rsp_data_in  = {2'b00, gesture, bgdc_pkg::seg_of(digit_in), digit_in};
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= bgdc_pkg::DEBOUNCE_RST;
         double_ff        <= bgdc_pkg::DOUBLE_RST;
         long_ff          <= bgdc_pkg::LONG_RST;
         repeat_ff        <= bgdc_pkg::REPEAT_RST;
         held_ff          <= 1'b0;
         long_active_ff   <= 1'b0;
         click_pending_ff <= 1'b0;
         skip_release_ff  <= 1'b0;
         since_edge_ff    <= '0;
         since_repeat_ff  <= '0;
         since_release_ff <= '0;
         digit_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               bgdc_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata;
               bgdc_pkg::CSR_DOUBLE:   double_ff   <= csr_wdata;
               bgdc_pkg::CSR_LONG:     long_ff     <= csr_wdata;
               bgdc_pkg::CSR_REPEAT:   repeat_ff   <= csr_wdata;
               default: ;
            endcase
         end
         held_ff          <= held_in;
         long_active_ff   <= long_active_in;
         click_pending_ff <= click_pending_in;
         skip_release_ff  <= skip_release_in;
         since_edge_ff    <= since_edge_in;
         since_repeat_ff  <= since_repeat_in;
         since_release_ff <= since_release_in;
         digit_ff         <= digit_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[src/button_gesture_digit_counter.sv]
// Top level of the button gesture digit counter.
// The block takes one item per clock while it is not held by back-pressure: a 1 ms tick
// (req_tuser = 0) or a button edge (req_tuser = 1, new level in req_tdata[0]), and returns
// exactly one result per item with the digit, its seven-segment pattern and the gesture the
// item completed. An item passes a registered classifying stage, a two-entry queue and the
// back end, whose state update writes the result register. The sustained rate is one item
// per cycle while results are taken. Timing registers must be written through
// csr_we/csr_index/csr_wdata while no item is in flight; the block does not enforce it.
module button_gesture_digit_counter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bgdc_pkg::REQ_DATA_W-1:0]     req_tdata,   // [0] pressed_level, [7:1] zero
   input  logic                                req_tuser,   // [0] opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bgdc_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [3:0] digit, [10:4] segments,
                                                            // [13:11] gesture, [15:14] zero
   input  logic                                csr_we,
   input  logic [bgdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bgdc_pkg::CNT_W-1:0]          csr_wdata
);

   logic              front_valid, front_ready;
   bgdc_pkg::cmd_type front_cmd;
   logic              back_valid, back_ready;
   bgdc_pkg::cmd_type back_cmd;

   // Classify incoming items.
   bgdc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd        (front_cmd),
      .cmd_ready  (front_ready)
   );

   // Decouple the front end from the back end.
   bgdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   // Gesture state machine and result register.
   bgdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[src/bgdc_checker.sv]
// Port-level checker of the button gesture digit counter, bound to the top level.
`include "button_gesture_digit_counter_defines.svh"

module bgdc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bgdc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic rsp_stall;
   logic rsp_fields_ok;

   // A result is waiting when it is offered and not taken.
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign rsp_fields_ok = (rsp_tdata[3:0] <= 4'd9) && (rsp_tdata[13:11] <= 3'd5);

   // A waiting result stays offered.
   `BGDC_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid, "result dropped in stall")

   // A waiting result keeps its value.
   `BGDC_ASSERT(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_tdata), "result changed")

   // The digit stays decimal and the gesture code stays defined.
   `BGDC_ASSERT(a_rsp_range, clock, reset, rsp_tvalid |-> rsp_fields_ok, "field out of range")

   // No result is offered right after reset.
   `BGDC_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid, "result after reset")

endmodule

bind button_gesture_digit_counter bgdc_checker u_bgdc_checker (.*);

[tb/button_gesture_digit_counter_tb.sv]
// Self-checking testbench for the button gesture digit counter: directed table, then random gestures.
module button_gesture_digit_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 5000;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int REPORT_MAX  = 10;

   // One result item, laid out as rsp_tdata[13:0].
   typedef struct packed {
      logic [bgdc_pkg::GEST_W-1:0]  gesture;
      logic [bgdc_pkg::SEG_W-1:0]   segments;
      logic [bgdc_pkg::DIGIT_W-1:0] digit;
   } display_type;

   typedef enum logic [1:0] {STEP_TICK, STEP_EDGE, STEP_CSR} step_kind_type;

   // One row of the directed table.
   typedef struct packed {
      step_kind_type                  kind;
      logic [bgdc_pkg::CSR_IDX_W-1:0] reg_sel;
      logic [bgdc_pkg::CNT_W-1:0]     value;
      logic                           typed;
      display_type                    want;
   } step_type;

   // Common-cathode patterns, element 0 in the lowest bits.
   localparam logic [9:0][bgdc_pkg::SEG_W-1:0] SEVEN_SEG = {
      7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [bgdc_pkg::REQ_DATA_W-1:0] req_tdata   = '0;   // [0] pressed_level, [7:1] zero
   logic                            req_tuser   = 1'b0; // [0] opcode
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [bgdc_pkg::RSP_DATA_W-1:0] rsp_tdata;  // [3:0] digit, [10:4] segments, [13:11] gesture
   logic                            csr_we      = 1'b0;
   logic [bgdc_pkg::CSR_IDX_W-1:0]  csr_index   = '0;
   logic [bgdc_pkg::CNT_W-1:0]      csr_wdata   = '0;

   button_gesture_digit_counter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Timing registers as the block should hold them.
   logic [bgdc_pkg::CNT_W-1:0] t_debounce = bgdc_pkg::DEBOUNCE_RST;
   logic [bgdc_pkg::CNT_W-1:0] t_double   = bgdc_pkg::DOUBLE_RST;
   logic [bgdc_pkg::CNT_W-1:0] t_long     = bgdc_pkg::LONG_RST;
   logic [bgdc_pkg::CNT_W-1:0] t_repeat   = bgdc_pkg::REPEAT_RST;

   // Gesture state of the button as the block should hold it.
   logic                         btn_held   = 1'b0;
   logic                         long_on    = 1'b0;
   logic                         click_wait = 1'b0;
   logic                         skip_up    = 1'b0;
   logic [bgdc_pkg::CNT_W-1:0]   ms_edge    = '0;
   logic [bgdc_pkg::CNT_W-1:0]   ms_repeat  = '0;
   logic [bgdc_pkg::CNT_W-1:0]   ms_release = '0;
   logic [bgdc_pkg::DIGIT_W-1:0] shown      = '0;

   display_type pending_displays[$];
   step_type    script[$];
   int unsigned items_sent  = 0;
   int unsigned burst_left  = 0;
   int unsigned mismatches  = 0;
   int unsigned stall_mode  = 0;
   int unsigned stall_left  = 0;

   // Millisecond counter that sticks at full scale.
   function automatic logic [bgdc_pkg::CNT_W-1:0] ms_bump(input logic [bgdc_pkg::CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Advances the gesture state by one item and returns the display it leaves.
   function automatic display_type next_display(input logic op, input logic lvl);
      display_type d;
      logic [bgdc_pkg::GEST_W-1:0] g;
      g = bgdc_pkg::GEST_NONE;
      if (op == bgdc_pkg::OP_TICK) begin
         ms_edge    = ms_bump(ms_edge);
         ms_repeat  = ms_bump(ms_repeat);
         ms_release = ms_bump(ms_release);
         if (btn_held) begin
            if (!long_on) begin
               if (ms_edge >= t_long) begin
                  long_on    = 1'b1;
                  click_wait = 1'b0;
                  shown      = (shown >= bgdc_pkg::DIGIT_MAX) ? '0 : shown + 1'b1;
                  ms_repeat  = '0;
                  g          = bgdc_pkg::GEST_LSTART;
               end
            end else if (ms_repeat >= t_repeat) begin
               shown     = (shown >= bgdc_pkg::DIGIT_MAX) ? '0 : shown + 1'b1;
               ms_repeat = '0;
               g         = bgdc_pkg::GEST_LREP;
            end
         end else if (click_wait && ms_release >= t_double) begin
            click_wait = 1'b0;
            shown      = (shown >= bgdc_pkg::DIGIT_MAX) ? '0 : shown + 1'b1;
            g          = bgdc_pkg::GEST_CLICK;
         end
      end else if (ms_edge >= t_debounce && lvl != btn_held) begin
         btn_held = lvl;
         ms_edge  = '0;
         if (btn_held) begin
            // A press inside the window turns the pending click into a double click.
            if (click_wait) begin
               click_wait = 1'b0;
               skip_up    = 1'b1;
               shown      = (shown == '0) ? bgdc_pkg::DIGIT_MAX : shown - 1'b1;
               g          = bgdc_pkg::GEST_DOUBLE;
            end else begin
               long_on = 1'b0;
            end
         end else begin
            if (skip_up) begin
               skip_up = 1'b0;
            end else if (long_on) begin
               long_on = 1'b0;
               g       = bgdc_pkg::GEST_LEND;
            end else begin
               click_wait = 1'b1;
               ms_release = '0;
            end
         end
      end
      d.digit    = shown;
      d.segments = SEVEN_SEG[shown];
      d.gesture  = g;
      return d;
   endfunction

   // Random register value, now and then one of the extremes.
   function automatic logic [bgdc_pkg::CNT_W-1:0] pick_timing(input int unsigned hi);
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return bgdc_pkg::CNT_MAX;
      return bgdc_pkg::CNT_W'($urandom_range(0, hi));
   endfunction

   task automatic add_step(input step_kind_type kind, input logic [bgdc_pkg::CSR_IDX_W-1:0] sel,
                           input logic [bgdc_pkg::CNT_W-1:0] value, input logic typed,
                           input display_type want);
      step_type s;
      s.kind    = kind;
      s.reg_sel = sel;
      s.value   = value;
      s.typed   = typed;
      s.want    = want;
      script.push_back(s);
   endtask

   // Drives one item after an optional gap between bursts and waits until it is taken.
   task automatic send_item(input logic op, input logic lvl, input display_type want);
      int unsigned gap;
      csr_we <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      pending_displays.push_back(want);
      items_sent++;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, lvl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic apply_item(input logic op, input logic lvl);
      send_item(op, lvl, next_display(op, lvl));
   endtask

   // Ticks carry a random level, which the block must ignore.
   task automatic apply_ticks(input int unsigned n);
      repeat (n) apply_item(bgdc_pkg::OP_TICK, 1'($urandom_range(0, 1)));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_displays.size() != 0) @(posedge clock);
   endtask

   // Register write; the block must be idle.
   task automatic write_timing(input logic [bgdc_pkg::CSR_IDX_W-1:0] sel,
                               input logic [bgdc_pkg::CNT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      unique case (sel)
         bgdc_pkg::CSR_DEBOUNCE: t_debounce = val;
         bgdc_pkg::CSR_DOUBLE:   t_double   = val;
         bgdc_pkg::CSR_LONG:     t_long     = val;
         bgdc_pkg::CSR_REPEAT:   t_repeat   = val;
      endcase
      @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input display_type want,
                                input display_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t: %s: expected digit %0d seg %h gesture %0d, got digit %0d seg %h %s %0d",
                  $realtime, what, want.digit, want.segments, want.gesture,
                  got.digit, got.segments, "gesture", got.gesture);
   endtask

   // Result checker: every result is matched against the oldest expectation.
   always @(posedge clock) begin : check_display
      display_type want;
      display_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(display_type)-1:0];
         if (pending_displays.size() == 0) begin
            note_mismatch("result with no item outstanding", '0, got);
         end else begin
            want = pending_displays.pop_front();
            if (got.digit != want.digit || got.segments != want.segments ||
                got.gesture != want.gesture)
               note_mismatch("result mismatch", want, got);
         end
      end
   end

   // Receiver: switches between always ready, light and heavy stalling.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(32, 256);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      step_type    row;
      display_type guess;
      int          hold_lim;
      int          wait_lim;
      int          pre_lim;
      int unsigned target;

      // Reset values: edges right after reset fall inside the debounce time.
      add_step(STEP_TICK, '0, 16'd0, 1'b1, {bgdc_pkg::GEST_NONE, 7'h3F, 4'd0});
      add_step(STEP_EDGE, '0, 16'd1, 1'b1, {bgdc_pkg::GEST_NONE, 7'h3F, 4'd0});
      add_step(STEP_EDGE, '0, 16'd0, 1'b1, {bgdc_pkg::GEST_NONE, 7'h3F, 4'd0});
      // Zero registers fire on the next tick.
      add_step(STEP_CSR, bgdc_pkg::CSR_DEBOUNCE, 16'd0, 1'b0, '0);
      add_step(STEP_CSR, bgdc_pkg::CSR_DOUBLE,   16'd0, 1'b0, '0);
      add_step(STEP_CSR, bgdc_pkg::CSR_LONG,     16'd2, 1'b0, '0);
      add_step(STEP_CSR, bgdc_pkg::CSR_REPEAT,   16'd0, 1'b0, '0);
      // An edge that keeps the level is ignored.
      add_step(STEP_EDGE, '0, 16'd0, 1'b1, {bgdc_pkg::GEST_NONE, 7'h3F, 4'd0});
      // Double click from zero wraps to nine, then the held press starts a long press.
      add_step(STEP_EDGE, '0, 16'd1, 1'b0, '0);
      add_step(STEP_EDGE, '0, 16'd0, 1'b0, '0);
      add_step(STEP_EDGE, '0, 16'd1, 1'b1, {bgdc_pkg::GEST_DOUBLE, 7'h6F, 4'd9});
      add_step(STEP_TICK, '0, 16'd0, 1'b0, '0);
      add_step(STEP_TICK, '0, 16'd1, 1'b1, {bgdc_pkg::GEST_LSTART, 7'h3F, 4'd0});
      add_step(STEP_TICK, '0, 16'd0, 1'b1, {bgdc_pkg::GEST_LREP, 7'h06, 4'd1});
      // That release belongs to the double click and gives no long end.
      add_step(STEP_EDGE, '0, 16'd0, 1'b0, '0);
      add_step(STEP_TICK, '0, 16'd0, 1'b0, '0);
      // Single click.
      add_step(STEP_EDGE, '0, 16'd1, 1'b0, '0);
      add_step(STEP_EDGE, '0, 16'd0, 1'b0, '0);
      add_step(STEP_TICK, '0, 16'd1, 1'b1, {bgdc_pkg::GEST_CLICK, 7'h5B, 4'd2});
      // Plain long press with its end.
      add_step(STEP_EDGE, '0, 16'd1, 1'b0, '0);
      add_step(STEP_TICK, '0, 16'd0, 1'b0, '0);
      add_step(STEP_TICK, '0, 16'd0, 1'b1, {bgdc_pkg::GEST_LSTART, 7'h4F, 4'd3});
      add_step(STEP_EDGE, '0, 16'd0, 1'b1, {bgdc_pkg::GEST_LEND, 7'h4F, 4'd3});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         if (row.kind == STEP_CSR) begin
            drain_results();
            write_timing(row.reg_sel, row.value);
         end else begin
            guess = next_display((row.kind == STEP_EDGE) ? bgdc_pkg::OP_EDGE : bgdc_pkg::OP_TICK,
                                 row.value[0]);
            send_item((row.kind == STEP_EDGE) ? bgdc_pkg::OP_EDGE : bgdc_pkg::OP_TICK,
                      row.value[0], row.typed ? row.want : guess);
         end
      end

      // Full-scale registers: nothing fires and early edges are ignored.
      drain_results();
      write_timing(bgdc_pkg::CSR_DEBOUNCE, bgdc_pkg::CNT_MAX);
      write_timing(bgdc_pkg::CSR_DOUBLE,   bgdc_pkg::CNT_MAX);
      write_timing(bgdc_pkg::CSR_LONG,     bgdc_pkg::CNT_MAX);
      write_timing(bgdc_pkg::CSR_REPEAT,   bgdc_pkg::CNT_MAX);
      apply_ticks(20);
      apply_item(bgdc_pkg::OP_EDGE, 1'b1);
      apply_ticks(20);
      apply_item(bgdc_pkg::OP_EDGE, 1'b0);

      // Random phases: mostly press and release sequences, with some noise.
      for (int p = 0; p < RAND_PHASES; p++) begin
         drain_results();
         write_timing(bgdc_pkg::CSR_DEBOUNCE, pick_timing(6));
         write_timing(bgdc_pkg::CSR_DOUBLE,   pick_timing(10));
         write_timing(bgdc_pkg::CSR_LONG,     pick_timing(15));
         write_timing(bgdc_pkg::CSR_REPEAT,   pick_timing(8));
         pre_lim  = (int'(t_debounce) > 8) ? 9 : int'(t_debounce) + 1;
         hold_lim = int'(t_long) + 2 * int'(t_repeat) + 4;
         if (hold_lim > 40) hold_lim = 40;
         wait_lim = int'(t_double) + 3;
         if (wait_lim > 30) wait_lim = 30;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
               apply_ticks($urandom_range(0, pre_lim));
               apply_item(bgdc_pkg::OP_EDGE, 1'b1);
               apply_ticks($urandom_range(0, hold_lim));
               apply_item(bgdc_pkg::OP_EDGE, 1'b0);
               apply_ticks($urandom_range(0, wait_lim));
            end else begin
               repeat ($urandom_range(1, 4))
                  apply_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/bgdc_pkg.sv
src/bgdc_front.sv
src/bgdc_queue.sv
src/bgdc_back.sv
src/button_gesture_digit_counter.sv
src/bgdc_checker.sv
tb/button_gesture_digit_counter_tb.sv
